// ----- rtl/core/four_connected_line_walker_assert.svh -----
// assertion macros shared by the line walker rtl
`ifndef FOUR_CONNECTED_LINE_WALKER_ASSERT_SVH
`define FOUR_CONNECTED_LINE_WALKER_ASSERT_SVH

// same-cycle implication
`define LFW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lfw_pkg.sv -----
// package: payload types, sequencer states and unit status for the line walker
package lfw_pkg;

    localparam int COORD_WIDTH = 16;

    typedef struct packed {
        logic                          action;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } t_in_req;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pixel_x;
        logic signed [COORD_WIDTH-1:0] pixel_y;
        logic                          reached_end;
        logic                          is_last;
    } t_out_req;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN_A,
        S_LEN_B,
        S_CHECK,
        S_EMIT0,
        S_PD_A,
        S_PD_B,
        S_QX_M,
        S_QX_D,
        S_QY_M,
        S_QY_D,
        S_EX,
        S_EY,
        S_EMIT1
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ----- rtl/core/lfw_mul.sv -----
// bit-serial shift-add multiplier for unsigned magnitudes
module lfw_mul import lfw_pkg::*; #(
    parameter int BW = 35,
    parameter int SW = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [BW-1:0]      i_mcand,
    input  logic [SW-1:0]      i_mplier,
    output t_unit_sts          o_sts,
    output logic [BW+SW-1:0]   o_prod
);

    localparam int PW = BW + SW;
    localparam int CW = (SW > 1) ? $clog2(SW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_mcand;
    logic [SW-1:0] r_mplier;
    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(SW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= PW'(i_mcand);
            r_mplier <= i_mplier;
            r_prod   <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[PW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[SW-1:1]};
        end
    end

    assign o_sts  = '{busy: r_busy, done: r_done};
    assign o_prod = r_prod;

endmodule

// ----- rtl/core/lfw_div.sv -----
// bit-serial restoring divider for unsigned magnitudes
module lfw_div import lfw_pkg::*; #(
    parameter int NW = 54,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_unit_sts     o_sts,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [NW-1:0] r_quo;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[NW-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DW'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[DW-1:0];
            end
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_sts = '{busy: r_busy, done: r_done};
    assign o_quo = r_quo;

endmodule

// ----- rtl/core/four_connected_line_walker.sv -----
// top level: 4-connected line walker sequencer with serial multiplier and divider
//
// channel   dir  valid/ready                  payload
// in        in   i_in_valid / o_in_ready      i_in_data  (t_in_req)
// out       out  o_out_valid / i_out_ready    o_out_data (t_out_req)
//
// start request: two serial multiplies for the squared length
// step request: per candidate six multiplies and two divides on the shared units
// finished or degenerate step: a check state, no result
// output register holds a result while a new request is taken in idle
// a stalled output holds the sequencer at the two emit points
// synchronous active-low reset clears walk state to zero
`include "four_connected_line_walker_assert.svh"

module four_connected_line_walker import lfw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    localparam int W    = COORD_WIDTH;
    localparam int DXW  = W + 1;
    localparam int UW   = W + 2;
    localparam int SW   = W + 3;
    localparam int BW   = 2 * W + 3;
    localparam int PRW  = BW + SW;
    localparam int LW   = 2 * W + 2;
    localparam int PDW  = 2 * W + 3;
    localparam int EW   = W + 3;
    localparam int DSW  = 2 * W + 6;

    t_state r_state, n_state;
    logic   r_go;
    logic   r_cand;
    logic   r_mneg;
    logic   r_step_y;

    logic signed [W-1:0]   r_ox, r_oy, r_tx, r_ty, r_wx, r_wy;
    logic signed [DXW-1:0] r_dx, r_dy;
    logic [LW-1:0]         r_len2;
    logic signed [PRW:0]   r_acc;
    logic signed [PDW-1:0] r_pdot;
    logic [PRW-1:0]        r_pmag;
    logic signed [EW-1:0]  r_ex, r_ey;
    logic signed [DSW-1:0] r_dist0;

    logic     r_out_valid;
    t_out_req r_out;

    logic in_acc, out_free;
    logic mul_start, div_start, emit0, emit1;
    t_unit_sts mul_sts, div_sts;
    logic [PRW-1:0] m_prod, d_quo;

    logic signed [W-1:0]   sx, sy, nx, ny;
    logic signed [UW-1:0]  px, py, ux, uy;
    logic signed [BW:0]    big;
    logic signed [SW:0]    sml;
    logic [BW-1:0]         big_mag;
    logic [SW-1:0]         small_mag;
    logic signed [PRW:0]   prod_s, sum_s;
    logic signed [EW-1:0]  qs, enew;
    logic signed [DSW-1:0] dist_sum;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign sx = (r_dx > 0) ? W'(1) : '1;
    assign sy = (r_dy > 0) ? W'(1) : '1;
    assign px = UW'(r_wx) + ((r_cand == 1'b0) ? UW'(sx) : '0);
    assign py = UW'(r_wy) + ((r_cand == 1'b1) ? UW'(sy) : '0);
    assign ux = px - UW'(r_ox);
    assign uy = py - UW'(r_oy);

    always_comb begin
        case (r_state)
            S_LEN_A: begin
                big = (BW+1)'(r_dx);
                sml = (SW+1)'(r_dx);
            end
            S_LEN_B: begin
                big = (BW+1)'(r_dy);
                sml = (SW+1)'(r_dy);
            end
            S_PD_A: begin
                big = (BW+1)'(ux);
                sml = (SW+1)'(r_dx);
            end
            S_PD_B: begin
                big = (BW+1)'(uy);
                sml = (SW+1)'(r_dy);
            end
            S_QX_M: begin
                big = (BW+1)'(r_pdot);
                sml = (SW+1)'(r_dx);
            end
            S_QY_M: begin
                big = (BW+1)'(r_pdot);
                sml = (SW+1)'(r_dy);
            end
            S_EX: begin
                big = (BW+1)'(r_ex);
                sml = (SW+1)'(r_ex);
            end
            S_EY: begin
                big = (BW+1)'(r_ey);
                sml = (SW+1)'(r_ey);
            end
            default: begin
                big = '0;
                sml = '0;
            end
        endcase
    end

    assign big_mag   = big[BW] ? BW'(-big) : big[BW-1:0];
    assign small_mag = sml[SW] ? SW'(-sml) : sml[SW-1:0];

    assign prod_s   = r_mneg ? -$signed({1'b0, m_prod}) : $signed({1'b0, m_prod});
    assign sum_s    = r_acc + prod_s;
    assign dist_sum = sum_s[DSW-1:0];

    assign qs   = r_mneg ? -$signed({1'b0, d_quo[EW-2:0]}) : $signed({1'b0, d_quo[EW-2:0]});
    assign enew = ((r_state == S_QX_D) ? EW'(ux) : EW'(uy)) - qs;

    assign nx = r_step_y ? r_wx : r_wx + sx;
    assign ny = r_step_y ? r_wy + sy : r_wy;

    lfw_mul #(.BW(BW), .SW(SW)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (big_mag),
        .i_mplier (small_mag),
        .o_sts    (mul_sts),
        .o_prod   (m_prod)
    );

    lfw_div #(.NW(PRW), .DW(LW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_pmag),
        .i_divisor  (r_len2),
        .o_sts      (div_sts),
        .o_quo      (d_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.action == ACT_START) ? S_LEN_A : S_CHECK;
                end
            end
            S_LEN_A: if (mul_sts.done) n_state = S_LEN_B;
            S_LEN_B: if (mul_sts.done) n_state = S_IDLE;
            S_CHECK: begin
                if ((r_wx == r_tx && r_wy == r_ty) || (r_ox == r_tx && r_oy == r_ty)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT0;
                end
            end
            S_EMIT0: if (out_free) n_state = S_PD_A;
            S_PD_A:  if (mul_sts.done) n_state = S_PD_B;
            S_PD_B:  if (mul_sts.done) n_state = S_QX_M;
            S_QX_M:  if (mul_sts.done) n_state = S_QX_D;
            S_QX_D:  if (div_sts.done) n_state = S_QY_M;
            S_QY_M:  if (mul_sts.done) n_state = S_QY_D;
            S_QY_D:  if (div_sts.done) n_state = S_EX;
            S_EX:    if (mul_sts.done) n_state = S_EY;
            S_EY: begin
                if (mul_sts.done) begin
                    n_state = r_cand ? S_EMIT1 : S_PD_A;
                end
            end
            S_EMIT1: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        emit0      = 1'b0;
        emit1      = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_LEN_A, S_LEN_B, S_PD_A, S_PD_B, S_QX_M, S_QY_M, S_EX, S_EY: mul_start = r_go;
            S_QX_D, S_QY_D: div_start = r_go;
            S_EMIT0: emit0 = out_free;
            S_EMIT1: emit1 = out_free;
            S_CHECK: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_wx        <= '0;
            r_wy        <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
            if (emit0 || emit1) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && i_in_data.action == ACT_START) begin
                r_ox <= i_in_data.start_x;
                r_oy <= i_in_data.start_y;
                r_tx <= i_in_data.end_x;
                r_ty <= i_in_data.end_y;
                r_wx <= i_in_data.start_x;
                r_wy <= i_in_data.start_y;
                r_dx <= DXW'(i_in_data.end_x) - DXW'(i_in_data.start_x);
                r_dy <= DXW'(i_in_data.end_y) - DXW'(i_in_data.start_y);
            end
            if (emit1) begin
                r_wx <= nx;
                r_wy <= ny;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_mneg <= big[BW] ^ sml[SW];
        end
        if (emit0) begin
            r_cand <= 1'b0;
            r_out  <= '{pixel_x: r_wx, pixel_y: r_wy, reached_end: 1'b0, is_last: 1'b0};
        end
        if (emit1) begin
            r_out <= '{pixel_x: nx, pixel_y: ny,
                       reached_end: (nx == r_tx && ny == r_ty), is_last: 1'b1};
        end
        if (mul_sts.done) begin
            case (r_state)
                S_LEN_A, S_PD_A, S_EX: r_acc <= prod_s;
                S_LEN_B: r_len2 <= sum_s[LW-1:0];
                S_PD_B:  r_pdot <= sum_s[PDW-1:0];
                S_QX_M, S_QY_M: r_pmag <= m_prod;
                S_EY: begin
                    if (r_cand) begin
                        r_step_y <= (r_dist0 > dist_sum);
                    end else begin
                        r_dist0 <= dist_sum;
                        r_cand  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (div_sts.done) begin
            if (r_state == S_QX_D) begin
                r_ex <= enew;
            end else begin
                r_ey <= enew;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LFW_ASSERT_NOW(a_idle_units_free, i_clk, i_rst_n, o_in_ready, !mul_sts.busy && !div_sts.busy, "units busy while idle")
    `LFW_ASSERT_NOW(a_units_exclusive, i_clk, i_rst_n, mul_sts.busy, !div_sts.busy, "multiplier and divider both busy")
    `LFW_ASSERT_NEXT(a_second_result, i_clk, i_rst_n, emit1, o_out_valid && o_out_data.is_last, "second result missing")
    `LFW_ASSERT_NOW(a_first_not_end, i_clk, i_rst_n, o_out_valid && !o_out_data.is_last, !o_out_data.reached_end, "first result flagged at end")

endmodule
